// ===== design/tcw_pkg.sv =====
// Shared types, constants and helper functions of the text console character writer.
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int CELL_W     = CHAR_W + ATTR_W;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h07;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CAPTURE,
      OP_READ,
      OP_STORE,
      OP_NEWLINE,
      OP_RETURN,
      OP_BACKSPACE,
      OP_SCROLL,
      OP_RESPOND
   } dp_op_type;

   typedef enum logic [2:0] {
      CC_NEWLINE,
      CC_RETURN,
      CC_BACKSPACE,
      CC_TAB,
      CC_PRINT
   } char_class_type;

   typedef struct packed {
      dp_op_type op;
      logic      blank;
   } dp_cmd_type;

   typedef struct packed {
      logic           clear_last;
      logic           scroll_last;
      logic           scroll_pend;
      logic           tab_stop;
      logic           is_read;
      char_class_type char_class;
      logic           rsp_free;
   } dp_status_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] ch);
      char_class_type cc;
      cc = CC_PRINT;
      if (ch == CHAR_NEWLINE) cc = CC_NEWLINE;
      else if (ch == CHAR_RETURN) cc = CC_RETURN;
      else if (ch == CHAR_BACKSPACE) cc = CC_BACKSPACE;
      else if (ch == CHAR_TAB) cc = CC_TAB;
      return cc;
   endfunction

   // Column is a multiple of seven: fold octal digits, since 8 is 1 modulo 7.
   function automatic logic tab_stop_hit(input logic [COL_W-1:0] col);
      logic [3:0] s1;
      logic [3:0] s2;
      s1 = 4'(col[6]) + 4'(col[5:3]) + 4'(col[2:0]);
      s2 = 4'(s1[3]) + 4'(s1[2:0]);
      return (s2 == 4'd0) || (s2 == 4'd7);
   endfunction

endpackage

`default_nettype wire

// ===== design/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// Controller state machine that sequences requests through the datapath.
`default_nettype none

module tcw_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire tcw_pkg::dp_status_type status,
   output tcw_pkg::dp_cmd_type         cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_TAB,
      S_SCROLL,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      cmd.blank = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_read) begin
               cmd.op   = OP_READ;
               state_in = S_DONE;
            end else begin
               unique case (status.char_class)
                  CC_NEWLINE: begin
                     cmd.op   = OP_NEWLINE;
                     state_in = S_CHECK;
                  end
                  CC_RETURN: begin
                     cmd.op   = OP_RETURN;
                     state_in = S_DONE;
                  end
                  CC_BACKSPACE: begin
                     cmd.op   = OP_BACKSPACE;
                     state_in = S_DONE;
                  end
                  CC_TAB: begin
                     cmd.op    = OP_STORE;
                     cmd.blank = 1'b1;
                     state_in  = S_CHECK;
                  end
                  default: begin
                     cmd.op   = OP_STORE;
                     state_in = S_CHECK;
                  end
               endcase
            end
         end
         S_CHECK: begin
            // scroll first, then keep spacing until the tab stop
            priority if (status.scroll_pend) begin
               state_in = S_SCROLL;
            end else if (status.char_class == CC_TAB && !status.tab_stop) begin
               state_in = S_TAB;
            end else begin
               state_in = S_DONE;
            end
         end
         S_TAB: begin
            cmd.op    = OP_STORE;
            cmd.blank = 1'b1;
            state_in  = S_CHECK;
         end
         S_SCROLL: begin
            cmd.op = OP_SCROLL;
            if (status.scroll_last) state_in = S_CHECK;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.op   = OP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/tcw_datapath.sv =====
// Datapath: cursor, scroll offset, attribute, screen memory and result register.
`default_nettype none

module tcw_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tcw_pkg::dp_cmd_type           cmd,
   output tcw_pkg::dp_status_type             status,
   input  wire logic                          req_command,
   input  wire logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tcw_pkg::ROW_W-1:0]     req_read_row,
   input  wire logic [tcw_pkg::COL_W-1:0]     req_read_col,
   input  wire logic                          csr_wr_en,
   input  wire logic [tcw_pkg::ATTR_W-1:0]    csr_wr_data,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic      [tcw_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic      [tcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic      [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic      [tcw_pkg::ATTR_W-1:0]    rsp_cell_attr,
   output logic                               rsp_scrolled
);
   import tcw_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ATTR_W-1:0] attr_ff;
   logic              scroll_pend_ff, scroll_pend_in;
   logic              scrolled_ff, scrolled_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              read_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ROW_W-1:0]  rrow_ff;
   logic [COL_W-1:0]  rcol_ff;

   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic              rsp_sc_ff, rsp_sc_in;

   logic [ROW_W-1:0]  row_pick;
   logic [ROW_W:0]    row_sum;
   logic [ROW_W-1:0]  phys_row;
   logic [COL_W-1:0]  col_pick;
   logic [ADDR_W-1:0] addr;
   logic [CELL_W-1:0] wr_data;
   logic              wr_en;
   logic              rd_en;
   logic [CELL_W-1:0] rd_data;
   logic              read_in_range;
   logic              clear_last;
   logic              scroll_last;

   assign clear_last    = (sweep_ff == ADDR_W'(CELL_COUNT - 1));
   assign scroll_last   = (sweep_ff[COL_W-1:0] == COL_W'(COLUMNS - 1));
   assign read_in_range = (rrow_ff < ROW_W'(ROWS)) && (rcol_ff < COL_W'(COLUMNS));

   // Logical row to physical row over the circular row store.
   always_comb begin
      row_pick = (cmd.op == OP_READ) ? rrow_ff : row_ff;
      row_sum  = {1'b0, row_pick} + {1'b0, top_ff};
      if (cmd.op == OP_SCROLL) begin
         phys_row = top_ff;
      end else if (row_sum >= (ROW_W + 1)'(ROWS)) begin
         phys_row = ROW_W'(row_sum - (ROW_W + 1)'(ROWS));
      end else begin
         phys_row = row_sum[ROW_W-1:0];
      end
      unique case (cmd.op)
         OP_READ:      col_pick = rcol_ff;
         OP_BACKSPACE: col_pick = COL_W'(col_ff - 1'b1);
         OP_SCROLL:    col_pick = sweep_ff[COL_W-1:0];
         default:      col_pick = col_ff;
      endcase
      if (cmd.op == OP_CLEAR) begin
         addr = sweep_ff;
      end else begin
         addr = ADDR_W'(ADDR_W'(phys_row) * ADDR_W'(COLUMNS)) + ADDR_W'(col_pick);
      end
      unique case (cmd.op)
         OP_CLEAR: wr_data = {RESET_ATTR, CHAR_BLANK};
         OP_STORE: wr_data = {attr_ff, cmd.blank ? CHAR_BLANK : char_ff};
         default:  wr_data = {attr_ff, CHAR_BLANK};
      endcase
      wr_en = (cmd.op == OP_CLEAR) || (cmd.op == OP_STORE) || (cmd.op == OP_SCROLL) ||
              ((cmd.op == OP_BACKSPACE) && (col_ff != '0));
      rd_en = (cmd.op == OP_READ);
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      top_in         = top_ff;
      scroll_pend_in = scroll_pend_ff;
      scrolled_in    = scrolled_ff;
      sweep_in       = sweep_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_cell_in    = rsp_cell_ff;
      rsp_sc_in      = rsp_sc_ff;
      unique case (cmd.op)
         OP_CLEAR: begin
            sweep_in = clear_last ? '0 : ADDR_W'(sweep_ff + 1'b1);
         end
         OP_CAPTURE: begin
            scrolled_in = 1'b0;
         end
         OP_STORE, OP_NEWLINE: begin
            if (cmd.op == OP_STORE && col_ff != COL_W'(COLUMNS - 1)) begin
               col_in = COL_W'(col_ff + 1'b1);
            end else begin
               col_in = '0;
               // hold the last row and flag a scroll
               if (row_ff == ROW_W'(ROWS - 1)) begin
                  scroll_pend_in = 1'b1;
               end else begin
                  row_in = ROW_W'(row_ff + 1'b1);
               end
            end
         end
         OP_RETURN: begin
            col_in = '0;
         end
         OP_BACKSPACE: begin
            if (col_ff != '0) col_in = COL_W'(col_ff - 1'b1);
         end
         OP_SCROLL: begin
            if (scroll_last) begin
               sweep_in       = '0;
               top_in         = (top_ff == ROW_W'(ROWS - 1)) ? '0 : ROW_W'(top_ff + 1'b1);
               scroll_pend_in = 1'b0;
               scrolled_in    = 1'b1;
            end else begin
               sweep_in = ADDR_W'(sweep_ff + 1'b1);
            end
         end
         OP_RESPOND: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = col_ff;
            rsp_row_in   = row_ff;
            rsp_cell_in  = (read_ff && read_in_range) ? rd_data : '0;
            rsp_sc_in    = scrolled_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         top_ff         <= '0;
         scroll_pend_ff <= 1'b0;
         scrolled_ff    <= 1'b0;
         sweep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         top_ff         <= top_in;
         scroll_pend_ff <= scroll_pend_in;
         scrolled_ff    <= scrolled_in;
         sweep_ff       <= sweep_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_wr_en) begin
         attr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CAPTURE) begin
         read_ff <= (req_command == CMD_READ);
         char_ff <= req_char_code;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_sc_ff   <= rsp_sc_in;
   end

   always_comb begin
      status.clear_last  = clear_last;
      status.scroll_last = scroll_last;
      status.scroll_pend = scroll_pend_ff;
      status.tab_stop    = tab_stop_hit(col_ff);
      status.is_read     = read_ff;
      status.char_class  = classify(char_ff);
      status.rsp_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_char  = rsp_cell_ff[CHAR_W-1:0];
   assign rsp_cell_attr  = rsp_cell_ff[CELL_W-1:CHAR_W];
   assign rsp_scrolled   = rsp_sc_ff;

`ifndef SYNTHESIS
   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      (col_ff < COL_W'(COLUMNS)) && (row_ff < ROW_W'(ROWS)) && (top_ff < ROW_W'(ROWS)))
      else $error("cursor or top row outside the screen");

   a_scroll_on_last_row: assert property (@(posedge clock) disable iff (reset)
      scroll_pend_ff |-> (row_ff == ROW_W'(ROWS - 1)) && (col_ff == '0))
      else $error("scroll pending away from the start of the last row");

   a_scroll_advances_top: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SCROLL) && scroll_last |=> scrolled_ff && !scroll_pend_ff &&
         (top_ff != $past(top_ff)))
      else $error("finished scroll did not advance the top row");

   a_sweep_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_CAPTURE) |-> (sweep_ff == '0))
      else $error("sweep counter not at rest when a request is taken");
`endif

endmodule

`default_nettype wire

// ===== design/text_console_char_writer.sv =====
// Top level of the text console character writer.
`default_nettype none

// Text console character writer: keeps an 80 x 25 screen of character cells
// (character in the low byte, attribute in the high byte) and a cursor. A
// put request handles one character (newline, carriage return, backspace,
// tab, or a printable byte stored with the csr_wr_data attribute); a read
// request returns one cell in on-screen coordinates, zero outside the screen.
// Every request gives one response with the cursor after the request. After
// reset the block sweeps the screen memory to blanks, one cell a cycle,
// before req_tready first rises; attribute writes are taken at any time.
// Requests run one at a time through a controller and a single write/read
// port of the screen memory: each is captured, then decoded; a read, a
// printable character, newline, carriage return or backspace then goes to
// its response, a tab stores blanks until the next tab stop, and a scroll
// blanks the new bottom row first. A finished response waits in its own
// register, so the next request is taken while it is still held.
module text_console_char_writer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // char_code [7:0], read_row [12:8], read_col [19:13], zero fill
   input  wire logic [tcw_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command [0]
   input  wire logic                            req_tuser,
   // response
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // cursor_col [6:0], cursor_row [11:7], cell_char [19:12], cell_attr [27:20],
   // scrolled [28], zero fill
   output logic      [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // attribute register
   input  wire logic                            csr_wr_en,
   input  wire logic [tcw_pkg::ATTR_W-1:0]      csr_wr_data
);
   import tcw_pkg::*;

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [COL_W-1:0]  cursor_col;
   logic [ROW_W-1:0]  cursor_row;
   logic [CHAR_W-1:0] cell_char;
   logic [ATTR_W-1:0] cell_attr;
   logic              scrolled;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_tuser),
      .req_char_code  (req_tdata[7:0]),
      .req_read_row   (req_tdata[12:8]),
      .req_read_col   (req_tdata[19:13]),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_cursor_col (cursor_col),
      .rsp_cursor_row (cursor_row),
      .rsp_cell_char  (cell_char),
      .rsp_cell_attr  (cell_attr),
      .rsp_scrolled   (scrolled)
   );

   assign rsp_tdata = {3'b000, scrolled, cell_attr, cell_char, cursor_row, cursor_col};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the text console character writer: self-predicting stream checks.
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int TAB_STOP       = 7;

   typedef struct packed {
      logic              cmd;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } console_req_type;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CHAR_W-1:0] ch;
      logic [ATTR_W-1:0] attr;
      logic              scrolled;
   } console_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = CMD_PUT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [ATTR_W-1:0]      csr_wr_data = '0;

   // screen mirror and cursor
   logic [CELL_W-1:0] screen_model [CELL_COUNT];
   int unsigned       cur_col;
   int unsigned       cur_row;
   int unsigned       top_row;
   logic [ATTR_W-1:0] attr_model;

   console_rsp_type awaited_status [$];
   console_rsp_type status_due;
   int              mismatches = 0;
   int              idle_cycles = 0;
   bit              sender_fast = 1'b0;
   bit              receiver_fast = 1'b0;
   int              rsp_wait = 0;
   int              rsp_hold_cycles = 0;

   text_console_char_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned phys_index(int unsigned r, int unsigned c);
      return ((r + top_row) % ROWS) * COLUMNS + c;
   endfunction

   function automatic void clear_console();
      for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {RESET_ATTR, CHAR_BLANK};
      cur_col    = 0;
      cur_row    = 0;
      top_row    = 0;
      attr_model = RESET_ATTR;
   endfunction

   // wrap at the last column, scroll below the last row
   function automatic bit settle_cursor();
      if (cur_col >= COLUMNS) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= ROWS) begin
         for (int c = 0; c < COLUMNS; c++)
            screen_model[top_row * COLUMNS + c] = {attr_model, CHAR_BLANK};
         top_row = (top_row + 1) % ROWS;
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit store_glyph(logic [CHAR_W-1:0] ch);
      screen_model[phys_index(cur_row, cur_col)] = {attr_model, ch};
      cur_col++;
      return settle_cursor();
   endfunction

   function automatic bit put_character(logic [CHAR_W-1:0] ch);
      bit did_scroll;
      did_scroll = 1'b0;
      case (ch)
         CHAR_NEWLINE: begin
            cur_col    = 0;
            cur_row++;
            did_scroll = settle_cursor();
         end
         CHAR_RETURN: cur_col = 0;
         CHAR_BACKSPACE: begin
            if (cur_col > 0) begin
               cur_col--;
               screen_model[phys_index(cur_row, cur_col)] = {attr_model, CHAR_BLANK};
            end
         end
         CHAR_TAB: begin
            do begin
               if (store_glyph(CHAR_BLANK)) did_scroll = 1'b1;
            end while (cur_col % TAB_STOP != 0);
         end
         default: did_scroll = store_glyph(ch);
      endcase
      return did_scroll;
   endfunction

   function automatic console_rsp_type advance_console(console_req_type rq);
      console_rsp_type   rs;
      logic [CELL_W-1:0] cell_word;
      rs = '0;
      if (rq.cmd == CMD_PUT) begin
         rs.scrolled = put_character(rq.ch);
      end else if (rq.row < ROWS && rq.col < COLUMNS) begin
         cell_word = screen_model[phys_index(rq.row, rq.col)];
         rs.ch     = cell_word[CHAR_W-1:0];
         rs.attr   = cell_word[CELL_W-1:CHAR_W];
      end
      rs.col = cur_col[COL_W-1:0];
      rs.row = cur_row[ROW_W-1:0];
      return rs;
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_request(console_req_type rq);
      int gap;
      if ($urandom_range(0, 49) == 0) sender_fast = !sender_fast;
      gap = sender_fast ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.cmd;
      req_tdata  <= REQ_TDATA_W'({rq.col, rq.row, rq.ch});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_status.push_back(advance_console(rq));
      @(negedge clock);
   endtask

   task automatic send_put(logic [CHAR_W-1:0] ch);
      console_req_type rq;
      rq     = '0;
      rq.cmd = CMD_PUT;
      rq.ch  = ch;
      send_request(rq);
   endtask

   task automatic send_read(int unsigned r, int unsigned c);
      console_req_type rq;
      rq     = '0;
      rq.cmd = CMD_READ;
      rq.row = r[ROW_W-1:0];
      rq.col = c[COL_W-1:0];
      send_request(rq);
   endtask

   // drop valid and hold until every response is back
   task automatic wait_idle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (awaited_status.size() != 0) @(negedge clock);
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      attr_model = value;
   endtask

   // mostly text with control characters and reads; wild mode uses any byte
   function automatic console_req_type draw_request(int unsigned newline_pct, bit wild);
      console_req_type rq;
      int unsigned     r;
      rq     = console_req_type'({$urandom, $urandom});
      rq.cmd = CMD_PUT;
      r      = $urandom_range(0, 99);
      if (r < 15) begin
         rq.cmd = CMD_READ;
         rq.row = ROW_W'($urandom_range(0, ROWS - 1));
         rq.col = COL_W'($urandom_range(0, COLUMNS - 1));
      end else if (r < 18) begin
         rq.cmd = CMD_READ;
      end else if (r < 18 + newline_pct) begin
         rq.ch = CHAR_NEWLINE;
      end else if (r < 21 + newline_pct) begin
         rq.ch = CHAR_RETURN;
      end else if (r < 26 + newline_pct) begin
         rq.ch = CHAR_BACKSPACE;
      end else if (r < 30 + newline_pct) begin
         rq.ch = CHAR_TAB;
      end else if (!wild) begin
         rq.ch = CHAR_W'($urandom_range(8'h21, 8'h7E));
      end
      return rq;
   endfunction

   task automatic send_text(int count, int unsigned newline_pct, bit wild);
      for (int i = 0; i < count; i++) send_request(draw_request(newline_pct, wild));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      send_read(0, 0);
      send_read(ROWS - 1, COLUMNS - 1);
      send_read(ROWS, 0);
      send_read(31, 127);
      send_read(0, COLUMNS);
      send_put(CHAR_BACKSPACE);
      send_put(8'h41);
      send_put(8'h00);
      send_put(8'hFF);
      send_put(CHAR_BACKSPACE);
      send_put(CHAR_TAB);
      send_put(CHAR_TAB);
      send_put(CHAR_RETURN);
      send_put(CHAR_NEWLINE);
      send_read(0, 0);
      send_read(0, 1);
      send_read(0, 2);
      write_attribute(8'hFF);
      send_put(8'h7E);
      send_put(CHAR_TAB);
      send_read(1, 0);
      send_read(1, 1);
   endtask

   task automatic test_long_lines();
      write_attribute(8'h00);
      send_text(400, 1, 1'b0);
   endtask

   task automatic test_short_lines();
      write_attribute(8'hFF);
      send_text(400, 12, 1'b0);
   endtask

   task automatic test_any_bytes();
      for (int p = 0; p < 5; p++) begin
         write_attribute(ATTR_W'($urandom_range(0, 255)));
         send_text(100, 4, 1'b1);
      end
   endtask

   // hold the receiver off so the block backs up into the request side
   task automatic test_receiver_stall();
      bit saved;
      saved           = sender_fast;
      sender_fast     = 1'b1;
      rsp_hold_cycles = 300;
      send_text(60, 6, 1'b0);
      sender_fast = saved;
   endtask

   task automatic test_drain_pauses();
      for (int p = 0; p < 8; p++) begin
         write_attribute(ATTR_W'($urandom_range(0, 255)));
         send_text(30, 6, p[0]);
         wait_idle();
      end
   endtask

   task automatic test_reset_attribute();
      write_attribute(RESET_ATTR);
      send_text(250, 5, 1'b1);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_status.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none actual %h",
                     $time, rsp_tdata);
         end else begin
            status_due = awaited_status.pop_front();
            check_field("cursor_col", 32'(status_due.col),      32'(rsp_tdata[6:0]));
            check_field("cursor_row", 32'(status_due.row),      32'(rsp_tdata[11:7]));
            check_field("cell_char",  32'(status_due.ch),       32'(rsp_tdata[19:12]));
            check_field("cell_attr",  32'(status_due.attr),     32'(rsp_tdata[27:20]));
            check_field("scrolled",   32'(status_due.scrolled), 32'(rsp_tdata[28]));
         end
         if ($urandom_range(0, 49) == 0) receiver_fast = !receiver_fast;
         rsp_wait = receiver_fast ? 0 : $urandom_range(0, 14);
      end
   end

   // receiver ready: long hold first, then the per-response wait
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      clear_console();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_long_lines();
      test_short_lines();
      test_any_bytes();
      test_receiver_stall();
      test_drain_pauses();
      test_reset_attribute();
      wait_idle();
      repeat (200) @(negedge clock);
      if (mismatches == 0 && awaited_status.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
